// File: rtl/acsf_pkg.sv
// ----------------------------------------------------------------------------
// acsf_pkg: shared types and constants for the candidate skip filter
// Field widths, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package acsf_pkg;

	localparam int DIST_W  = 48;
	localparam int RANK_W  = 16;
	localparam int COUNT_W = 20;
	localparam int LEAF_W  = 3;
	localparam int MASK_W  = 8;

	localparam int ELEM_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// APB port: widest register is 48 bits, so 64-bit data and 8-byte stride
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 6;
	localparam int REG_LSB = 3;

	localparam logic MODE_PROJ  = 1'b0;
	localparam logic MODE_FULL  = 1'b1;
	localparam logic KIND_TREE  = 1'b0;
	localparam logic KIND_EXACT = 1'b1;

	typedef enum logic [PADDR_W-REG_LSB-1:0] {
		REG_RANK_ROOT     = 3'd0,
		REG_RANK_LOW      = 3'd1,
		REG_RANK_HIGH     = 3'd2,
		REG_APPROX_MID    = 3'd3,
		REG_APPROX_MIDHI  = 3'd4,
		REG_APPROX_TOP    = 3'd5,
		REG_COUNT_SPLIT   = 3'd6,
		REG_LEAF_MASK     = 3'd7
	} acsf_reg_t;

	localparam logic [RANK_W-1:0]  RST_RANK_ROOT    = 16'd8727;
	localparam logic [RANK_W-1:0]  RST_RANK_LOW     = 16'd3286;
	localparam logic [RANK_W-1:0]  RST_RANK_HIGH    = 16'd14742;
	localparam logic [DIST_W-1:0]  RST_APPROX_MID   = 48'd905904;
	localparam logic [DIST_W-1:0]  RST_APPROX_MIDHI = 48'd985334;
	localparam logic [DIST_W-1:0]  RST_APPROX_TOP   = 48'd680264;
	localparam logic [COUNT_W-1:0] RST_COUNT_SPLIT  = 20'd34339;
	localparam logic [MASK_W-1:0]  RST_LEAF_MASK    = 8'd224;

	typedef struct packed {
		logic [RANK_W-1:0]  rank_split_root;
		logic [RANK_W-1:0]  rank_split_low;
		logic [RANK_W-1:0]  rank_split_high;
		logic [DIST_W-1:0]  approx_split_mid;
		logic [DIST_W-1:0]  approx_split_midhigh;
		logic [DIST_W-1:0]  approx_split_top;
		logic [COUNT_W-1:0] count_split;
		logic [MASK_W-1:0]  leaf_skip_mask;
	} acsf_cfg_t;

endpackage

// File: rtl/acsf_if.sv
// ----------------------------------------------------------------------------
// acsf_if: element and result channels of the candidate skip filter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface acsf_elem_if #(
	parameter int ELEM_BITS = acsf_pkg::ELEM_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic signed [ELEM_BITS-1:0]    query_elem;
	logic signed [ELEM_BITS-1:0]    cand_elem;
	logic                           last;
	logic [acsf_pkg::RANK_W-1:0]    rank;
	logic [acsf_pkg::COUNT_W-1:0]   insert_count;

	modport source (output valid, mode, query_elem, cand_elem, last, rank, insert_count,
		input ready);
	modport sink (input valid, mode, query_elem, cand_elem, last, rank, insert_count,
		output ready);
endinterface

interface acsf_result_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic                           skip;
	logic [acsf_pkg::LEAF_W-1:0]    leaf_index;
	logic [acsf_pkg::DIST_W-1:0]    distance;

	modport source (output valid, kind, skip, leaf_index, distance, input ready);
	modport sink (input valid, kind, skip, leaf_index, distance, output ready);
endinterface

// File: rtl/acsf_regs.sv
// ----------------------------------------------------------------------------
// acsf_regs: APB register file for the tree thresholds and leaf mask
// Zero-wait writes on the access phase; reads return the stored value.
// ----------------------------------------------------------------------------
module acsf_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [acsf_pkg::PADDR_W-1:0]  paddr,
	input  logic [acsf_pkg::PDATA_W-1:0]  pwdata,
	output logic [acsf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output acsf_pkg::acsf_cfg_t           cfg
);
	import acsf_pkg::*;

	acsf_cfg_t cfg_q;
	acsf_reg_t reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = acsf_reg_t'(paddr[PADDR_W-1:REG_LSB]);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank_split_root      <= RST_RANK_ROOT;
			cfg_q.rank_split_low       <= RST_RANK_LOW;
			cfg_q.rank_split_high      <= RST_RANK_HIGH;
			cfg_q.approx_split_mid     <= RST_APPROX_MID;
			cfg_q.approx_split_midhigh <= RST_APPROX_MIDHI;
			cfg_q.approx_split_top     <= RST_APPROX_TOP;
			cfg_q.count_split          <= RST_COUNT_SPLIT;
			cfg_q.leaf_skip_mask       <= RST_LEAF_MASK;
		end else if (wr_en) begin
			case (reg_sel)
				REG_RANK_ROOT:    cfg_q.rank_split_root      <= pwdata[RANK_W-1:0];
				REG_RANK_LOW:     cfg_q.rank_split_low       <= pwdata[RANK_W-1:0];
				REG_RANK_HIGH:    cfg_q.rank_split_high      <= pwdata[RANK_W-1:0];
				REG_APPROX_MID:   cfg_q.approx_split_mid     <= pwdata[DIST_W-1:0];
				REG_APPROX_MIDHI: cfg_q.approx_split_midhigh <= pwdata[DIST_W-1:0];
				REG_APPROX_TOP:   cfg_q.approx_split_top     <= pwdata[DIST_W-1:0];
				REG_COUNT_SPLIT:  cfg_q.count_split          <= pwdata[COUNT_W-1:0];
				REG_LEAF_MASK:    cfg_q.leaf_skip_mask       <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RANK_ROOT:    prdata = PDATA_W'(cfg_q.rank_split_root);
			REG_RANK_LOW:     prdata = PDATA_W'(cfg_q.rank_split_low);
			REG_RANK_HIGH:    prdata = PDATA_W'(cfg_q.rank_split_high);
			REG_APPROX_MID:   prdata = PDATA_W'(cfg_q.approx_split_mid);
			REG_APPROX_MIDHI: prdata = PDATA_W'(cfg_q.approx_split_midhigh);
			REG_APPROX_TOP:   prdata = PDATA_W'(cfg_q.approx_split_top);
			REG_COUNT_SPLIT:  prdata = PDATA_W'(cfg_q.count_split);
			REG_LEAF_MASK:    prdata = PDATA_W'(cfg_q.leaf_skip_mask);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/acsf_front.sv
// ----------------------------------------------------------------------------
// acsf_front: element intake, difference and square
// Takes one element pair per cycle while the queue accepts, registers the difference, squares it
// into the queue together with the phase tags and tree features.
// ----------------------------------------------------------------------------
module acsf_front #(
	parameter int ELEM_BITS = acsf_pkg::ELEM_BITS_DEF,
	parameter int ENT_W     = 2 + acsf_pkg::RANK_W + acsf_pkg::COUNT_W + 2*ELEM_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	acsf_elem_if.sink        elem,
	output logic             push_valid,
	input  logic             push_ready,
	output logic [ENT_W-1:0] push_data
);
	import acsf_pkg::*;

	localparam int DIFF_W = ELEM_BITS + 1;
	localparam int SQ_W   = 2*ELEM_BITS + 1;

	logic                  s1_valid_q;
	logic [DIFF_W-1:0]     diff_s1;
	logic                  mode_s1;
	logic                  last_s1;
	logic [RANK_W-1:0]     rank_s1;
	logic [COUNT_W-1:0]    count_s1;
	logic [DIFF_W-1:0]     diff;
	logic [DIFF_W-1:0]     mag;
	logic [2*DIFF_W-1:0]   sq_full;
	logic                  accept;

	// stage 1 is free when empty or when its item moves into the queue
	assign elem.ready = !s1_valid_q || push_ready;
	assign accept     = elem.valid && elem.ready;

	assign diff = {elem.query_elem[ELEM_BITS-1], elem.query_elem}
		- {elem.cand_elem[ELEM_BITS-1], elem.cand_elem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (elem.ready) begin
			s1_valid_q <= elem.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_s1  <= diff;
			mode_s1  <= elem.mode;
			last_s1  <= elem.last;
			rank_s1  <= elem.rank;
			count_s1 <= elem.insert_count;
		end
	end

	assign mag     = diff_s1[DIFF_W-1] ? (~diff_s1 + 1'b1) : diff_s1;
	assign sq_full = mag * mag;

	assign push_valid = s1_valid_q;
	assign push_data  = {mode_s1, last_s1, rank_s1, count_s1, sq_full[SQ_W-1:0]};

	ast_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !push_ready) |=> (s1_valid_q && $stable(diff_s1)))
		else $error("front stage dropped a stalled element");

endmodule

// File: rtl/acsf_fifo.sv
// ----------------------------------------------------------------------------
// acsf_fifo: short decoupling queue between front and back
// Register-based ring with occupancy count; head visible without delay.
// ----------------------------------------------------------------------------
module acsf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = acsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	ast_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond its depth");

endmodule

// File: rtl/acsf_back.sv
// ----------------------------------------------------------------------------
// acsf_back: saturating accumulate, tree walk and result register
// Pops squared differences, sums them; on a last element hands the sum to
// the tree stage and clears the sum.
// ----------------------------------------------------------------------------
module acsf_back #(
	parameter int ELEM_BITS = acsf_pkg::ELEM_BITS_DEF,
	parameter int ENT_W     = 2 + acsf_pkg::RANK_W + acsf_pkg::COUNT_W + 2*ELEM_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acsf_pkg::acsf_cfg_t  cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [ENT_W-1:0]     pop_data,
	acsf_result_if.source        result
);
	import acsf_pkg::*;

	localparam int SQ_W  = 2*ELEM_BITS + 1;
	localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
	localparam logic [SUM_W-1:0] SUM_LIMIT = {{(SUM_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

	logic                e_mode;
	logic                e_last;
	logic [RANK_W-1:0]   e_rank;
	logic [COUNT_W-1:0]  e_count;
	logic [SQ_W-1:0]     e_sq;

	logic [DIST_W-1:0]   sum_q;
	logic [SUM_W-1:0]    sum_ext;
	logic [DIST_W-1:0]   new_sum;
	logic                pop;

	logic                res_valid_s1;
	logic                mode_s1;
	logic [RANK_W-1:0]   rank_s1;
	logic [COUNT_W-1:0]  count_s1;
	logic [DIST_W-1:0]   dist_s1;
	logic                s1_free;

	logic [LEAF_W-1:0]   leaf;
	logic                out_valid_q;
	logic                out_advance;
	logic                kind_q;
	logic                skip_q;
	logic [LEAF_W-1:0]   leaf_q;
	logic [DIST_W-1:0]   dist_q;

	assign {e_mode, e_last, e_rank, e_count, e_sq} = pop_data;

	assign out_advance = !out_valid_q || result.ready;
	assign s1_free     = !res_valid_s1 || out_advance;
	// a non-last element only feeds the sum, so it never waits on the tree stage
	assign pop_ready   = !e_last || s1_free;
	assign pop         = pop_valid && pop_ready;

	assign sum_ext = SUM_W'(sum_q) + SUM_W'(e_sq);
	assign new_sum = (sum_ext > SUM_LIMIT) ? {DIST_W{1'b1}} : sum_ext[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				sum_q <= e_last ? '0 : new_sum;
			end
			if (s1_free) begin
				res_valid_s1 <= pop && e_last;
			end
			if (out_advance) begin
				out_valid_q <= res_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && e_last) begin
			mode_s1  <= e_mode;
			rank_s1  <= e_rank;
			count_s1 <= e_count;
			dist_s1  <= new_sum;
		end
	end

	always_comb begin
		if (rank_s1 <= cfg.rank_split_root) begin
			if (rank_s1 <= cfg.rank_split_low) begin
				leaf = (count_s1 <= cfg.count_split) ? 3'd0 : 3'd1;
			end else begin
				leaf = (dist_s1 <= cfg.approx_split_mid) ? 3'd2 : 3'd3;
			end
		end else if (rank_s1 <= cfg.rank_split_high) begin
			leaf = (dist_s1 <= cfg.approx_split_midhigh) ? 3'd4 : 3'd5;
		end else begin
			leaf = (dist_s1 <= cfg.approx_split_top) ? 3'd6 : 3'd7;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_s1 && out_advance) begin
			dist_q <= dist_s1;
			if (mode_s1 == MODE_PROJ) begin
				kind_q <= KIND_TREE;
				skip_q <= cfg.leaf_skip_mask[leaf];
				leaf_q <= leaf;
			end else begin
				kind_q <= KIND_EXACT;
				skip_q <= 1'b0;
				leaf_q <= '0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = kind_q;
	assign result.skip       = skip_q;
	assign result.leaf_index = leaf_q;
	assign result.distance   = dist_q;

	ast_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && e_last) |=> (sum_q == '0))
		else $error("running sum not cleared after a last element");

	ast_exact_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_EXACT) |-> (!skip_q && leaf_q == '0))
		else $error("exact distance result carries a tree verdict");

endmodule

// File: rtl/ann_candidate_skip_filter.sv
// ----------------------------------------------------------------------------
// ann_candidate_skip_filter: candidate distance and skip-verdict engine
// A last element passes the front, queue, tree stage and output registers before its result is valid.
// Throughput: one element per cycle unless stalled; the 48-bit saturating add is the loop.
// Output stalls back up through a QUEUE_DEPTH-entry queue, then the intake.
// Reset: arst_n clears the running sum, pipeline valids and queue; the
// threshold and leaf mask registers return to their default values.
// ----------------------------------------------------------------------------
module ann_candidate_skip_filter #(
	parameter int ELEM_BITS   = acsf_pkg::ELEM_BITS_DEF,
	parameter int QUEUE_DEPTH = acsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// element stream in, results out
	acsf_elem_if.sink                     elem,
	acsf_result_if.source                 result,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [acsf_pkg::PADDR_W-1:0]  paddr,
	input  logic [acsf_pkg::PDATA_W-1:0]  pwdata,
	output logic [acsf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import acsf_pkg::*;

	// queue entry: mode, last, rank, insert count, squared difference
	localparam int ENT_W = 2 + RANK_W + COUNT_W + 2*ELEM_BITS + 1;

	acsf_cfg_t        cfg;
	logic             push_valid;
	logic             push_ready;
	logic [ENT_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [ENT_W-1:0] pop_data;

	// thresholds and leaf mask; the user writes them only while no candidate is in flight; not enforced here
	acsf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: take the element pair, difference, then square into the queue
	acsf_front #(
		.ELEM_BITS (ELEM_BITS),
		.ENT_W     (ENT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem       (elem),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple: let the back end stall on the result channel without
	// stopping the intake at once
	acsf_fifo #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: accumulate with saturation; on a last element walk the tree
	// (projected phase) or pass the exact sum (full phase) to the output
	acsf_back #(
		.ELEM_BITS (ELEM_BITS),
		.ENT_W     (ENT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule
